FILE: rtl/ggs_pkg.sv
`timescale 1ns / 1ps

package ggs_pkg;

    localparam int ANGLE_W = 16;
    localparam int POS_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 36;
    // 17-bit diff, pre-scaled by 2^14, grown by CORDIC gain and sqrt(2)
    localparam int CORD_W  = 35;
    localparam int CORD_SCALE = 14;
    localparam int ATAN_IDX_W = 5;

    localparam logic [1:0] CFG_FWD_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ROT_GAIN   = 2'd1;
    localparam logic [1:0] CFG_DIST_THR   = 2'd2;
    localparam logic [1:0] CFG_ANGLE_THR  = 2'd3;

    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER     = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANGLE_NEG_QUARTER = 16'hC000;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // atan(2^-i) in binary-angle units, 32768 = pi
    function automatic angle_t atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        angle_t a;
        begin
            case (idx)
                5'd0:    a = 16'sd8192;
                5'd1:    a = 16'sd4836;
                5'd2:    a = 16'sd2555;
                5'd3:    a = 16'sd1297;
                5'd4:    a = 16'sd651;
                5'd5:    a = 16'sd326;
                5'd6:    a = 16'sd163;
                5'd7:    a = 16'sd81;
                5'd8:    a = 16'sd41;
                5'd9:    a = 16'sd20;
                5'd10:   a = 16'sd10;
                5'd11:   a = 16'sd5;
                5'd12:   a = 16'sd3;
                5'd13:   a = 16'sd1;
                5'd14:   a = 16'sd1;
                default: a = 16'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

FILE: rtl/ggs_mul.sv
`timescale 1ns / 1ps

module ggs_mul
    import ggs_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/ggs_cordic.sv
`timescale 1ns / 1ps

module ggs_cordic
    import ggs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  diff_t  dx,
    input  diff_t  dy,
    output logic   done,
    output angle_t bearing
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    angle_t                   z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [CORD_W-1:0] xs, ys, dx_ext, dy_ext;
    angle_t                   step_angle;
    logic                     last_step;

    assign dx_ext     = CORD_W'(dx);
    assign dy_ext     = CORD_W'(dy);
    assign xs         = x_reg >>> step_reg;
    assign ys         = y_reg >>> step_reg;
    assign step_angle = atan_lut(ATAN_IDX_W'(step_reg));
    assign last_step  = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = '0;
            if (dx == '0 && dy == '0)
            begin
                z_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                if (dx < 0)
                begin
                    // pre-rotate into the right half plane
                    if (dy >= 0)
                    begin
                        x_next = dy_ext <<< CORD_SCALE;
                        y_next = (-dx_ext) <<< CORD_SCALE;
                        z_next = ANGLE_QUARTER;
                    end
                    else
                    begin
                        x_next = (-dy_ext) <<< CORD_SCALE;
                        y_next = dx_ext <<< CORD_SCALE;
                        z_next = ANGLE_NEG_QUARTER;
                    end
                end
                else
                begin
                    x_next = dx_ext <<< CORD_SCALE;
                    y_next = dy_ext <<< CORD_SCALE;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_angle;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_angle;
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign bearing = z_reg;

endmodule

FILE: rtl/go_to_goal_steering.sv
`timescale 1ns / 1ps

// channel | valid     | ready     | payload
// --------+-----------+-----------+-----------------------------------------
// in      | in_valid  | in_ready  | kind, pos_x, pos_y, heading
// out     | out_valid | out_ready | linear_speed, angular_speed, arrived
// cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One word in, one word out. After the accepting edge the sequencer runs S_DIFF, S_SQX,
// S_SQY, S_THR, S_CMP, S_CORD (the CORDIC micro-rotation loop), S_GAIN, S_SCALE and
// S_OUT; when arrived, S_CMP goes straight to S_OUT. The shared 18x18 multiplier
// registers each product. in_ready returns in the same cycle as the result.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register and does not block the next input word, but the next result
// holds the sequencer in S_OUT until the first one is taken.
// Reset clears poses to zero and loads register defaults. cfg_ready is always high.

module go_to_goal_steering
    import ggs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [ANGLE_W-1:0] heading,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               linear_speed,
    output logic signed [16:0]        angular_speed,
    output logic                      arrived,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_THR   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_CORD  = 4'd6;
    localparam logic [3:0] S_GAIN  = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [15:0] fwd_speed_reg, fwd_speed_next;
    logic [15:0] rot_gain_reg, rot_gain_next;
    logic [15:0] dist_thr_reg, dist_thr_next;
    logic [14:0] angle_thr_reg, angle_thr_next;

    logic signed [POS_W-1:0] own_x_reg, own_x_next;
    logic signed [POS_W-1:0] own_y_reg, own_y_next;
    angle_t                  own_hdg_reg, own_hdg_next;
    logic signed [POS_W-1:0] goal_x_reg, goal_x_next;
    logic signed [POS_W-1:0] goal_y_reg, goal_y_next;

    diff_t        dx_reg, dx_next;
    diff_t        dy_reg, dy_next;
    logic [32:0]  acc_reg, acc_next;
    angle_t       err_reg, err_next;

    logic [15:0]        lin_res_reg, lin_res_next;
    logic signed [16:0] ang_res_reg, ang_res_next;
    logic               arr_res_reg, arr_res_next;

    logic [15:0]        lin_out_reg, lin_out_next;
    logic signed [16:0] ang_out_reg, ang_out_next;
    logic               arr_out_reg, arr_out_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     cord_start, cord_done;
    angle_t                   bearing;

    logic signed [PROD_W-1:0] prod_round;
    logic signed [16:0]       err_ext, err_mag;
    logic                     in_fire, cfg_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid;

    ggs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ggs_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .done    (cord_done),
        .bearing (bearing)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_SQY:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_THR:
            begin
                mul_a = MUL_W'({2'b00, dist_thr_reg});
                mul_b = MUL_W'({2'b00, dist_thr_reg});
            end
            S_GAIN:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'({2'b00, rot_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // truncate toward zero on the divide by 2^15
    assign prod_round = (prod < 0) ? (prod + PROD_W'(32767)) : prod;
    assign err_ext    = 17'(err_reg);
    assign err_mag    = (err_ext < 0) ? -err_ext : err_ext;

    assign cord_start = (state_reg == S_CMP) &&
                        !(acc_reg < {1'b0, prod[31:0]});

    always_comb
    begin
        state_next     = state_reg;
        fwd_speed_next = fwd_speed_reg;
        rot_gain_next  = rot_gain_reg;
        dist_thr_next  = dist_thr_reg;
        angle_thr_next = angle_thr_reg;
        own_x_next     = own_x_reg;
        own_y_next     = own_y_reg;
        own_hdg_next   = own_hdg_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        lin_res_next   = lin_res_reg;
        ang_res_next   = ang_res_reg;
        arr_res_next   = arr_res_reg;
        lin_out_next   = lin_out_reg;
        ang_out_next   = ang_out_reg;
        arr_out_next   = arr_out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_FWD_SPEED: fwd_speed_next = cfg_data;
                CFG_ROT_GAIN:  rot_gain_next  = cfg_data;
                CFG_DIST_THR:  dist_thr_next  = cfg_data;
                CFG_ANGLE_THR: angle_thr_next = cfg_data[14:0];
                default:       fwd_speed_next = fwd_speed_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!kind)
                    begin
                        own_x_next   = pos_x;
                        own_y_next   = pos_y;
                        own_hdg_next = heading;
                    end
                    else
                    begin
                        goal_x_next = pos_x;
                        goal_y_next = pos_y;
                    end
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                dx_next    = DIFF_W'(goal_x_reg) - DIFF_W'(own_x_reg);
                dy_next    = DIFF_W'(goal_y_reg) - DIFF_W'(own_y_reg);
                state_next = S_SQX;
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                acc_next   = prod[32:0];
                state_next = S_THR;
            end
            S_THR:
            begin
                acc_next   = acc_reg + prod[32:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cord_start)
                begin
                    state_next = S_CORD;
                end
                else
                begin
                    lin_res_next = '0;
                    ang_res_next = '0;
                    arr_res_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    err_next   = bearing - own_hdg_reg;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                ang_res_next = prod_round[31:15];
                lin_res_next = (err_mag < {2'b00, angle_thr_reg}) ? fwd_speed_reg : 16'd0;
                arr_res_next = 1'b0;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    lin_out_next   = lin_res_reg;
                    ang_out_next   = ang_res_reg;
                    arr_out_next   = arr_res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fwd_speed_reg <= 16'd256;
            rot_gain_reg  <= 16'd256;
            dist_thr_reg  <= 16'd26;
            angle_thr_reg <= 15'd1043;
            own_x_reg     <= '0;
            own_y_reg     <= '0;
            own_hdg_reg   <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fwd_speed_reg <= fwd_speed_next;
            rot_gain_reg  <= rot_gain_next;
            dist_thr_reg  <= dist_thr_next;
            angle_thr_reg <= angle_thr_next;
            own_x_reg     <= own_x_next;
            own_y_reg     <= own_y_next;
            own_hdg_reg   <= own_hdg_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        lin_res_reg <= lin_res_next;
        ang_res_reg <= ang_res_next;
        arr_res_reg <= arr_res_next;
        lin_out_reg <= lin_out_next;
        ang_out_reg <= ang_out_next;
        arr_out_reg <= arr_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_out_reg;
    assign angular_speed = ang_out_reg;
    assign arrived       = arr_out_reg;

endmodule
